// File: hw/rtl/cvg_pkg.sv
// cvg_pkg: shared types and constants of the circle vertex generator
// holds the circle job record and the Q2.30 cos/sin table of 2*pi/n
// no dependencies
package cvg_pkg;

    // widths fixed by the item fields
    localparam int CoordW = 32;
    localparam int RadiusW = 31;
    localparam int SegW = 5;
    localparam int TrigW = 32;
    // offset is held saturated to +-2^32, so 34 bits signed
    localparam int OffW = 34;

    // one classified circle request, as it waits between front and back
    typedef struct packed {
        logic signed [CoordW-1:0]  center_x;
        logic signed [CoordW-1:0]  center_y;
        logic signed [CoordW-1:0]  center_z;
        logic        [RadiusW-1:0] radius;
        logic        [SegW-1:0]    seg;
        logic signed [TrigW-1:0]   cos_q;
        logic signed [TrigW-1:0]   sin_q;
        logic                      line;
        logic        [CoordW-1:0]  rgba;
    } t_job;

    // Q2.30 cos(2*pi/n), row 0 duplicates n = 1
    function automatic logic signed [TrigW-1:0] cos_q30(input logic [SegW-1:0] idx);
        logic signed [TrigW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd1073741824;
            5'd1:  v = 32'sd1073741824;
            5'd2:  v = -32'sd1073741824;
            5'd3:  v = -32'sd536870912;
            5'd4:  v = 32'sd0;
            5'd5:  v = 32'sd331804471;
            5'd6:  v = 32'sd536870912;
            5'd7:  v = 32'sd669467077;
            5'd8:  v = 32'sd759250125;
            5'd9:  v = 32'sd822533958;
            5'd10: v = 32'sd868675383;
            5'd11: v = 32'sd903289103;
            5'd12: v = 32'sd929887697;
            5'd13: v = 32'sd950751168;
            5'd14: v = 32'sd967407956;
            5'd15: v = 32'sd980911963;
            5'd16: v = 32'sd992008094;
            5'd17: v = 32'sd1001234432;
            5'd18: v = 32'sd1008987269;
            5'd19: v = 32'sd1015563530;
            5'd20: v = 32'sd1021189159;
            default: v = 32'sd1026038487;
        endcase
        return v;
    endfunction

    // Q2.30 sin(2*pi/n), row 0 duplicates n = 1
    function automatic logic signed [TrigW-1:0] sin_q30(input logic [SegW-1:0] idx);
        logic signed [TrigW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd0;
            5'd1:  v = 32'sd0;
            5'd2:  v = 32'sd0;
            5'd3:  v = 32'sd929887697;
            5'd4:  v = 32'sd1073741824;
            5'd5:  v = 32'sd1021189159;
            5'd6:  v = 32'sd929887697;
            5'd7:  v = 32'sd839485162;
            5'd8:  v = 32'sd759250125;
            5'd9:  v = 32'sd690187940;
            5'd10: v = 32'sd631129609;
            5'd11: v = 32'sd580508657;
            5'd12: v = 32'sd536870912;
            5'd13: v = 32'sd498992707;
            5'd14: v = 32'sd465879117;
            5'd15: v = 32'sd436730144;
            5'd16: v = 32'sd410903207;
            5'd17: v = 32'sd387880286;
            5'd18: v = 32'sd367241332;
            5'd19: v = 32'sd348643400;
            5'd20: v = 32'sd331804471;
            default: v = 32'sd316490959;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/circle_vertex_generator_core.sv
// circle_vertex_generator_core: top level of the circle vertex generator
// joins the request queue (cvg_front) and the vertex sequencer (cvg_back)
// depends on cvg_pkg, cvg_front, cvg_back, cvg_rot
//
// usage:
//   requests enter on push/full; a request is taken when push is high and full low.
//   vertices leave on empty/pop; the oldest vertex sits on the o_vertex_* ports while
//   empty is low and is taken when pop is high. o_last marks the final vertex of a circle.
//   line_mode is written through cfg_valid/cfg_ready/i_cfg_data; the user must write it
//   only while the block is idle, which the block itself does not enforce. line mode gives
//   2n+2 vertices per circle, filled mode 3n, n being the clamped count. the first vertex
//   of a circle taken into an idle block passes the queue, the job capture and an emit
//   state into the result register. the sequencer writes one vertex a cycle into a single
//   result register while a circle runs and the receiver keeps up. each rotation step has
//   a product register, then shift, sum and clamp.
//   up to two requests queue ahead of the circle in progress.
//   a stalled receiver holds the sequencer on the current vertex; nothing is dropped.
//   reset empties the queue and the result register and sets line_mode to filled.
module circle_vertex_generator_core #(
    parameter int MAX_SEGMENTS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_x,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_y,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_z,
    input  logic [cvg_pkg::RadiusW-1:0]       i_radius,
    input  logic [cvg_pkg::SegW-1:0]          i_segment_count,
    input  logic [cvg_pkg::CoordW-1:0]        i_rgba,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_x,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_y,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_z,
    output logic [cvg_pkg::CoordW-1:0]        o_vertex_rgba,
    output logic                              o_last
);

    logic          r_line_mode;
    logic          w_job_valid;
    logic          w_job_take;
    cvg_pkg::t_job w_job;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            r_line_mode <= i_cfg_data;
        end
    end

    // request intake and job queue
    cvg_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_radius        (i_radius),
        .i_segment_count (i_segment_count),
        .i_rgba          (i_rgba),
        .i_line_mode     (r_line_mode),
        .o_job_valid     (w_job_valid),
        .o_job           (w_job),
        .i_job_take      (w_job_take)
    );

    // vertex sequencer and result register
    cvg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_job_take    (w_job_take),
        .empty         (empty),
        .pop           (pop),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_vertex_z    (o_vertex_z),
        .o_vertex_rgba (o_vertex_rgba),
        .o_last        (o_last)
    );

endmodule

// File: hw/rtl/cvg_front.sv
// cvg_front: accepts circle requests, clamps the segment count, looks up cos/sin
// and holds up to two classified jobs for the back end
// depends on cvg_pkg
module cvg_front #(
    parameter int MAX_SEGMENTS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_x,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_y,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_z,
    input  logic [cvg_pkg::RadiusW-1:0]       i_radius,
    input  logic [cvg_pkg::SegW-1:0]          i_segment_count,
    input  logic [cvg_pkg::CoordW-1:0]        i_rgba,
    input  logic                              i_line_mode,
    output logic                              o_job_valid,
    output cvg_pkg::t_job                     o_job,
    input  logic                              i_job_take
);

    localparam int Depth = 2;
    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [cvg_pkg::SegW-1:0] MaxSeg = cvg_pkg::SegW'(MAX_SEGMENTS);

    logic [cvg_pkg::SegW-1:0] w_seg;
    cvg_pkg::t_job            w_job;
    logic                     w_wr;
    logic                     w_rd;
    logic [PtrW-1:0]          r_wr_ptr;
    logic [PtrW-1:0]          r_rd_ptr;
    logic [CntW-1:0]          r_count;
    logic [PtrW-1:0]          n_wr_ptr;
    logic [PtrW-1:0]          n_rd_ptr;
    logic [CntW-1:0]          n_count;
    cvg_pkg::t_job            r_mem [Depth];

    // segment count: zero becomes one, saturate at the maximum
    always_comb begin
        w_seg = i_segment_count;
        if (w_seg == '0) begin
            w_seg = cvg_pkg::SegW'(1);
        end
        if (w_seg > MaxSeg) begin
            w_seg = MaxSeg;
        end
    end

    // classified job record
    always_comb begin
        w_job.center_x = i_center_x;
        w_job.center_y = i_center_y;
        w_job.center_z = i_center_z;
        w_job.radius   = i_radius;
        w_job.seg      = w_seg;
        w_job.cos_q    = cvg_pkg::cos_q30(w_seg);
        w_job.sin_q    = cvg_pkg::sin_q30(w_seg);
        w_job.line     = i_line_mode;
        w_job.rgba     = i_rgba;
    end

    // queue handshake
    assign full        = (r_count == CntW'(Depth));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign w_wr        = push & ~full;
    assign w_rd        = i_job_take & o_job_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + PtrW'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + PtrW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + CntW'(1);
        end else if (!w_wr && w_rd) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_job;
        end
    end

endmodule

// File: hw/rtl/cvg_rot.sv
// cvg_rot: one step of the rotation recurrence, products registered then summed
// floors each product by an arithmetic shift and saturates the offset to +-2^32
// depends on cvg_pkg
module cvg_rot (
    input  logic                              i_clk,
    input  logic signed [cvg_pkg::OffW-1:0]   i_cx,
    input  logic signed [cvg_pkg::OffW-1:0]   i_cy,
    input  logic signed [cvg_pkg::TrigW-1:0]  i_cos,
    input  logic signed [cvg_pkg::TrigW-1:0]  i_sin,
    output logic signed [cvg_pkg::OffW-1:0]   o_nx,
    output logic signed [cvg_pkg::OffW-1:0]   o_ny
);

    localparam int ProdW = cvg_pkg::OffW + cvg_pkg::TrigW;
    localparam int SumW = cvg_pkg::OffW + 1;
    localparam int Frac = 30;
    localparam logic signed [SumW-1:0] PosLim = SumW'(64'sd4294967296);
    localparam logic signed [SumW-1:0] NegLim = -PosLim;

    logic signed [ProdW-1:0]        r_cx_c;
    logic signed [ProdW-1:0]        r_cy_s;
    logic signed [ProdW-1:0]        r_cx_s;
    logic signed [ProdW-1:0]        r_cy_c;
    logic signed [cvg_pkg::OffW-1:0] w_a;
    logic signed [cvg_pkg::OffW-1:0] w_b;
    logic signed [cvg_pkg::OffW-1:0] w_d;
    logic signed [cvg_pkg::OffW-1:0] w_e;
    logic signed [SumW-1:0]         w_sx;
    logic signed [SumW-1:0]         w_sy;

    // product stage, always tracking the held offset
    always_ff @(posedge i_clk) begin
        r_cx_c <= i_cx * ProdW'(i_cos);
        r_cy_s <= i_cy * ProdW'(i_sin);
        r_cx_s <= i_cx * ProdW'(i_sin);
        r_cy_c <= i_cy * ProdW'(i_cos);
    end

    // floor by shift: products stay within +-2^62, so 34 bits remain
    assign w_a = r_cx_c[Frac +: cvg_pkg::OffW];
    assign w_b = r_cy_s[Frac +: cvg_pkg::OffW];
    assign w_d = r_cx_s[Frac +: cvg_pkg::OffW];
    assign w_e = r_cy_c[Frac +: cvg_pkg::OffW];

    assign w_sx = SumW'(w_a) - SumW'(w_b);
    assign w_sy = SumW'(w_d) + SumW'(w_e);

    // saturate the new offset
    always_comb begin
        if (w_sx > PosLim) begin
            o_nx = PosLim[cvg_pkg::OffW-1:0];
        end else if (w_sx < NegLim) begin
            o_nx = NegLim[cvg_pkg::OffW-1:0];
        end else begin
            o_nx = w_sx[cvg_pkg::OffW-1:0];
        end
        if (w_sy > PosLim) begin
            o_ny = PosLim[cvg_pkg::OffW-1:0];
        end else if (w_sy < NegLim) begin
            o_ny = NegLim[cvg_pkg::OffW-1:0];
        end else begin
            o_ny = w_sy[cvg_pkg::OffW-1:0];
        end
    end

endmodule

// File: hw/rtl/cvg_back.sv
// cvg_back: vertex sequencer for one circle job at a time plus the result register
// walks the outline or fan order and steps the offset through cvg_rot
// depends on cvg_pkg and cvg_rot
module cvg_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  cvg_pkg::t_job                    i_job,
    output logic                             o_job_take,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_x,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_y,
    output logic signed [cvg_pkg::CoordW-1:0] o_vertex_z,
    output logic [cvg_pkg::CoordW-1:0]        o_vertex_rgba,
    output logic                             o_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,  // waiting for a job
        S_PREP = 7'b0000010,  // products settle on the start offset
        S_CTR  = 7'b0000100,  // fan centre
        S_ROT  = 7'b0001000,  // current point, offset steps on transfer
        S_NXT  = 7'b0010000,  // point just reached
        S_TPT  = 7'b0100000,  // closing point, no step
        S_STA  = 7'b1000000   // start point, end of run
    } t_state;

    localparam int W = cvg_pkg::CoordW;
    localparam int IdxW = cvg_pkg::SegW + 1;

    t_state                          r_state;
    t_state                          n_state;
    cvg_pkg::t_job                   r_job;
    logic signed [cvg_pkg::OffW-1:0] r_cx;
    logic signed [cvg_pkg::OffW-1:0] r_cy;
    logic [cvg_pkg::SegW-1:0]        r_idx;
    logic [cvg_pkg::SegW-1:0]        n_idx;
    logic signed [cvg_pkg::OffW-1:0] w_nx;
    logic signed [cvg_pkg::OffW-1:0] w_ny;
    logic                            w_emits;
    logic                            w_space;
    logic                            w_emit;
    logic                            w_more;
    logic signed [W-1:0]             w_px;
    logic signed [W-1:0]             w_py;
    logic                            w_plast;
    logic                            r_ov;
    logic signed [W-1:0]             r_vx;
    logic signed [W-1:0]             r_vy;
    logic signed [W-1:0]             r_vz;
    logic [W-1:0]                    r_vrgba;
    logic                            r_vlast;

    // rotation step
    cvg_rot u_rot (
        .i_clk (i_clk),
        .i_cx  (r_cx),
        .i_cy  (r_cy),
        .i_cos (r_job.cos_q),
        .i_sin (r_job.sin_q),
        .o_nx  (w_nx),
        .o_ny  (w_ny)
    );

    // emit handshake against the result register
    assign w_emits    = (r_state != S_IDLE) && (r_state != S_PREP);
    assign w_space    = ~r_ov | pop;
    assign w_emit     = w_emits & w_space;
    assign o_job_take = (r_state == S_IDLE);
    assign w_more     = ({1'b0, r_idx} + IdxW'(1)) < {1'b0, r_job.seg};

    // vertex position for the current state
    always_comb begin
        w_px    = r_job.center_x + r_cx[W-1:0];
        w_py    = r_job.center_y + r_cy[W-1:0];
        w_plast = 1'b0;
        case (r_state)
            S_CTR: begin
                w_px = r_job.center_x;
                w_py = r_job.center_y;
            end
            S_STA: begin
                w_px    = r_job.center_x + W'(r_job.radius);
                w_py    = r_job.center_y;
                w_plast = 1'b1;
            end
            default: begin
                w_plast = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_PREP;
                    n_idx   = '0;
                end
            end
            S_PREP: begin
                n_state = r_job.line ? S_ROT : S_CTR;
            end
            S_CTR: begin
                if (w_emit) begin
                    n_state = w_more ? S_ROT : S_TPT;
                end
            end
            S_ROT: begin
                if (w_emit) begin
                    n_state = S_NXT;
                end
            end
            S_NXT: begin
                if (w_emit) begin
                    n_idx = r_idx + cvg_pkg::SegW'(1);
                    if (!r_job.line) begin
                        n_state = S_CTR;
                    end else begin
                        n_state = w_more ? S_ROT : S_TPT;
                    end
                end
            end
            S_TPT: begin
                if (w_emit) begin
                    n_state = S_STA;
                end
            end
            S_STA: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // job capture and offset update
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_cx  <= cvg_pkg::OffW'(i_job.radius);
            r_cy  <= '0;
        end else if (r_state == S_ROT && w_emit) begin
            r_cx <= w_nx;
            r_cy <= w_ny;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_vx    <= w_px;
            r_vy    <= w_py;
            r_vz    <= r_job.center_z;
            r_vrgba <= r_job.rgba;
            r_vlast <= w_plast;
        end
    end

    assign empty         = ~r_ov;
    assign o_vertex_x    = r_vx;
    assign o_vertex_y    = r_vy;
    assign o_vertex_z    = r_vz;
    assign o_vertex_rgba = r_vrgba;
    assign o_last        = r_vlast;

endmodule

// File: tb/sv/cvg_checker.sv
`timescale 1ns / 1ps
// cvg_checker: watches the request, vertex and config channels of the circle vertex generator
// predicts each circle's vertex run and compares it with what leaves the block
// depends on cvg_pkg for port widths
module cvg_checker #(
    parameter int MaxSegments = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic                              i_cfg_data,
    input  logic                              push,
    input  logic                              full,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_x,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_y,
    input  logic signed [cvg_pkg::CoordW-1:0] i_center_z,
    input  logic [cvg_pkg::RadiusW-1:0]       i_radius,
    input  logic [cvg_pkg::SegW-1:0]          i_segment_count,
    input  logic [cvg_pkg::CoordW-1:0]        i_rgba,
    input  logic                              empty,
    input  logic                              pop,
    input  logic signed [cvg_pkg::CoordW-1:0] o_vertex_x,
    input  logic signed [cvg_pkg::CoordW-1:0] o_vertex_y,
    input  logic signed [cvg_pkg::CoordW-1:0] o_vertex_z,
    input  logic [cvg_pkg::CoordW-1:0]        o_vertex_rgba,
    input  logic                              o_last,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int TableTop = 21;
    localparam longint OffsetLimit = 64'sd4294967296;
    localparam int MaxPrinted = 40;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] rgba;
        logic        last;
    } vertex_t;

    // Q2.30 cos and sin of 2*pi/n, row 0 same as n = 1
    int cos_step [0:TableTop] = '{
        1073741824, 1073741824, -1073741824, -536870912, 0, 331804471,
        536870912, 669467077, 759250125, 822533958, 868675383, 903289103,
        929887697, 950751168, 967407956, 980911963, 992008094, 1001234432,
        1008987269, 1015563530, 1021189159, 1026038487
    };
    int sin_step [0:TableTop] = '{
        0, 0, 0, 929887697, 1073741824, 1021189159,
        929887697, 839485162, 759250125, 690187940, 631129609, 580508657,
        536870912, 498992707, 465879117, 436730144, 410903207, 387880286,
        367241332, 348643400, 331804471, 316490959
    };

    vertex_t expected_vertices[$];
    logic    line_mode_q;
    int      fail_count;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < MaxPrinted)
            $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint clamp_offset(input longint v);
        if (v > OffsetLimit)
            return OffsetLimit;
        if (v < -OffsetLimit)
            return -OffsetLimit;
        return v;
    endfunction

    function automatic void add_vertex(input longint px, input longint py,
                                       input logic [31:0] z, input logic [31:0] rgba,
                                       input logic last);
        vertex_t v;
        v.x = px[31:0];
        v.y = py[31:0];
        v.z = z;
        v.rgba = rgba;
        v.last = last;
        expected_vertices.push_back(v);
    endfunction

    // expand one circle into its vertex run, rotating the offset step by step
    function automatic void tessellate_circle(input logic signed [31:0] cx_in,
                                              input logic signed [31:0] cy_in,
                                              input logic [31:0] z,
                                              input logic [30:0] radius,
                                              input logic [4:0] seg,
                                              input logic [31:0] rgba,
                                              input logic line);
        longint x0, y0, r, c, s, ox, oy, t;
        int n, idx;
        x0 = longint'(cx_in);
        y0 = longint'(cy_in);
        r = longint'({1'b0, radius});
        n = int'(seg);
        if (n == 0)
            n = 1;
        if (n > MaxSegments)
            n = MaxSegments;
        idx = (n > TableTop) ? TableTop : n;
        c = longint'(cos_step[idx]);
        s = longint'(sin_step[idx]);
        ox = r;
        oy = 0;
        if (line) begin
            // outline: pairs of neighbouring points, then closing pair
            for (int i = 0; i < n; i++) begin
                add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
                t = ox;
                ox = clamp_offset(((c * ox) >>> 30) - ((s * oy) >>> 30));
                oy = clamp_offset(((s * t) >>> 30) + ((c * oy) >>> 30));
                add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
            end
            add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
        end else begin
            // filled fan: centre, p_i, p_i+1 for each wedge but the last
            for (int i = 0; i + 1 < n; i++) begin
                add_vertex(x0, y0, z, rgba, 1'b0);
                add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
                t = ox;
                ox = clamp_offset(((c * ox) >>> 30) - ((s * oy) >>> 30));
                oy = clamp_offset(((s * t) >>> 30) + ((c * oy) >>> 30));
                add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
            end
            add_vertex(x0, y0, z, rgba, 1'b0);
            add_vertex(x0 + ox, y0 + oy, z, rgba, 1'b0);
        end
        add_vertex(x0 + r, y0, z, rgba, 1'b1);
    endfunction

    // sample all channels at the clock edge; vertex transfer checked before new circles
    always @(posedge i_clk) begin
        vertex_t exp_v;
        if (!i_rst_n) begin
            line_mode_q <= 1'b0;
            expected_vertices.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                line_mode_q <= i_cfg_data;
            if (pop && !empty) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch($sformatf("vertex x=%h y=%h with no circle pending",
                                              o_vertex_x, o_vertex_y));
                end else begin
                    exp_v = expected_vertices.pop_front();
                    if (o_vertex_x !== exp_v.x)
                        report_mismatch($sformatf("vertex_x got %h exp %h", o_vertex_x, exp_v.x));
                    if (o_vertex_y !== exp_v.y)
                        report_mismatch($sformatf("vertex_y got %h exp %h", o_vertex_y, exp_v.y));
                    if (o_vertex_z !== exp_v.z)
                        report_mismatch($sformatf("vertex_z got %h exp %h", o_vertex_z, exp_v.z));
                    if (o_vertex_rgba !== exp_v.rgba)
                        report_mismatch($sformatf("vertex_rgba got %h exp %h",
                                                  o_vertex_rgba, exp_v.rgba));
                    if (o_last !== exp_v.last)
                        report_mismatch($sformatf("last got %b exp %b", o_last, exp_v.last));
                end
            end
            if (push && !full)
                tessellate_circle(i_center_x, i_center_y, i_center_z, i_radius,
                                  i_segment_count, i_rgba, line_mode_q);
        end
        o_pending <= expected_vertices.size();
    end

    initial begin
        fail_count = 0;
        o_pending = 0;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives circle requests and line_mode writes into circle_vertex_generator_core
// depends on cvg_pkg, circle_vertex_generator_core and cvg_checker
module tb_top;

    localparam int CircleGap = 70;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        radius;
        logic [4:0]         seg;
        logic [31:0]        rgba;
    } circle_req_t;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic                              i_cfg_data;
    logic                              push;
    logic                              full;
    logic signed [cvg_pkg::CoordW-1:0] i_center_x;
    logic signed [cvg_pkg::CoordW-1:0] i_center_y;
    logic signed [cvg_pkg::CoordW-1:0] i_center_z;
    logic [cvg_pkg::RadiusW-1:0]       i_radius;
    logic [cvg_pkg::SegW-1:0]          i_segment_count;
    logic [cvg_pkg::CoordW-1:0]        i_rgba;
    logic                              empty;
    logic                              pop;
    logic signed [cvg_pkg::CoordW-1:0] o_vertex_x;
    logic signed [cvg_pkg::CoordW-1:0] o_vertex_y;
    logic signed [cvg_pkg::CoordW-1:0] o_vertex_z;
    logic [cvg_pkg::CoordW-1:0]        o_vertex_rgba;
    logic                              o_last;
    int                                fail_count;
    int                                pending;
    bit                                quiet;

    circle_vertex_generator_core #(.MAX_SEGMENTS(20)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_center_x(i_center_x), .i_center_y(i_center_y), .i_center_z(i_center_z),
        .i_radius(i_radius), .i_segment_count(i_segment_count), .i_rgba(i_rgba),
        .empty(empty), .pop(pop),
        .o_vertex_x(o_vertex_x), .o_vertex_y(o_vertex_y), .o_vertex_z(o_vertex_z),
        .o_vertex_rgba(o_vertex_rgba), .o_last(o_last)
    );

    cvg_checker #(.MaxSegments(20)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_center_x(i_center_x), .i_center_y(i_center_y), .i_center_z(i_center_z),
        .i_radius(i_radius), .i_segment_count(i_segment_count), .i_rgba(i_rgba),
        .empty(empty), .pop(pop),
        .o_vertex_x(o_vertex_x), .o_vertex_y(o_vertex_y), .o_vertex_z(o_vertex_z),
        .o_vertex_rgba(o_vertex_rgba), .o_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // vertex receiver: stalls about one cycle in eight unless in a quiet stretch
    always @(posedge i_clk) begin
        pop <= quiet || ($urandom_range(0, 99) >= 12);
    end

    // one circle transfer, with random idle cycles ahead of it
    task automatic send_circle(input circle_req_t r);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 12) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        i_center_x <= r.cx;
        i_center_y <= r.cy;
        i_center_z <= r.cz;
        i_radius <= r.radius;
        i_segment_count <= r.seg;
        i_rgba <= r.rgba;
        do @(posedge i_clk); while (full);
    endtask

    // hold off new circles until every predicted vertex has come out
    task automatic drain_vertices();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_line_mode(input logic v);
        cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // field extremes, every segment-count corner, wrapping centres
    function automatic circle_req_t directed_circle(input int k);
        circle_req_t r;
        r = '{cx: 32'sd0, cy: 32'sd0, cz: 32'sd0, radius: 31'h0001_0000,
              seg: 5'd4, rgba: 32'h0};
        case (k)
            1: begin
                r.seg = 5'd0;
                r.radius = '1;
                r.cx = 32'sh7FFF_FFFF;
                r.cy = 32'sh8000_0000;
            end
            2: begin
                r.seg = 5'd1;
                r.radius = '0;
                r.cx = 32'sh8000_0000;
                r.cy = 32'sh7FFF_FFFF;
            end
            3: r.seg = 5'd2;
            4: begin
                r.seg = 5'd3;
                r.radius = 31'h0064_8000;
                r.cx = 32'sh0010_0000;
                r.cy = -32'sh0020_0000;
            end
            5: begin
                r.seg = 5'd20;
                r.radius = '1;
                r.cx = 32'sh7FFF_FFFF;
                r.cy = 32'sh7FFF_FFFF;
            end
            6: r.seg = 5'd21;
            7: begin
                r.seg = 5'd31;
                r.rgba = 32'hFFFF_FFFF;
                r.cz = 32'sh8000_0000;
            end
            8: begin
                r.seg = 5'd5;
                r.cz = 32'sh7FFF_FFFF;
                r.rgba = 32'hA5C3_3C5A;
            end
            9: begin
                r.seg = 5'd12;
                r.radius = '1;
                r.cx = 32'sh8000_0000;
                r.cy = 32'sh8000_0000;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic circle_req_t random_circle();
        circle_req_t r;
        int pick;
        r.cx = $urandom;
        r.cy = $urandom;
        r.cz = $urandom;
        r.rgba = $urandom;
        // half the centres kept to moderate coordinates
        if ($urandom_range(0, 1) == 1) begin
            r.cx = {{6{r.cx[25]}}, r.cx[25:0]};
            r.cy = {{6{r.cy[25]}}, r.cy[25:0]};
        end
        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.radius = 31'($urandom);
        else if (pick == 2)
            r.radius = $urandom_range(0, 1) ? '1 : '0;
        else
            r.radius = 31'($urandom_range(0, 32'h00FF_FFFF));
        if ($urandom_range(0, 4) == 0)
            r.seg = 5'($urandom_range(0, 31));
        else
            r.seg = 5'($urandom_range(3, 20));
        return r;
    endfunction

    // stimulus and verdict
    initial begin
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        i_center_x <= '0;
        i_center_y <= '0;
        i_center_z <= '0;
        i_radius <= '0;
        i_segment_count <= '0;
        i_rgba <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed circles in filled mode (reset value), then in line mode
        for (int k = 0; k < 10; k++)
            send_circle(directed_circle(k));
        drain_vertices();
        write_line_mode(1'b1);
        for (int k = 0; k < 10; k++)
            send_circle(directed_circle(k));
        drain_vertices();

        // random phases, alternating mode, one phase with no idling at all
        for (int p = 0; p < 6; p++) begin
            write_line_mode(p[0]);
            quiet = (p == 3);
            for (int i = 0; i < 60; i++)
                send_circle(random_circle());
            drain_vertices();
        end
        quiet = 1'b0;

        repeat (CircleGap) @(posedge i_clk);
        if (fail_count == 0)
            $display("** circle_vertex_generator_core: PASSED **");
        else
            $display("** circle_vertex_generator_core: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("** circle_vertex_generator_core: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cvg_pkg.sv
hw/rtl/cvg_front.sv
hw/rtl/cvg_rot.sv
hw/rtl/cvg_back.sv
hw/rtl/circle_vertex_generator_core.sv
tb/sv/cvg_checker.sv
tb/sv/tb_top.sv
